### rtl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by the top level, the result queue and the checker.
`default_nettype none

package wsdf_pkg;

  localparam int unsigned LEN_BITS_DEF   = 64;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] HDR_CNT_EXT16 = 4'd2;
  localparam logic [3:0] HDR_CNT_EXT64 = 4'd8;
  localparam logic [3:0] HDR_CNT_KEY   = 4'd4;

  localparam logic [7:0] PONG_HDR = 8'h8A;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_PONG  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### rtl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: input register, header/payload parser, result queue.
// Depends on wsdf_pkg and wsdf_fifo.
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------
//   in      | in_valid_i / in_stall_o   | rx_byte_i
//   out     | out_valid_o / out_stall_i | kind_o, data_o, last_o
//
// One byte per cycle while in_stall_o is low; a result passes the input register and the result queue before it shows.
// The parser step needs queue room for two results; a ping header end queues two.
// With the output stalled, the input stalls once the queue holds FIFO_DEPTH-1 results.
// Reset is asynchronous, active low; the parser restarts at the first header byte.
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LEN_BITS   = wsdf_pkg::LEN_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = wsdf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            last_o
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic [2:0]          phase_q, phase_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [3:0]          op_q, op_d;
  logic                mask_q, mask_d;
  logic [31:0]         key_q, key_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [1:0]          mphase_q, mphase_d;

  logic                fire, room2, pop;
  logic                len_done, hdr_done, fin, empty;
  logic [7:0]          key_byte, pay_byte;
  logic [1:0]          push_raw, push_cnt;
  wsdf_pkg::result_t   res0, res1, head;

  assign fire       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    case (mphase_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign pay_byte = in_byte_q ^ key_byte;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    op_d     = op_q;
    mask_d   = mask_q;
    key_d    = key_q;
    rem_d    = rem_q;
    mphase_d = mphase_q;
    len_done = 1'b0;
    hdr_done = 1'b0;
    fin      = 1'b0;
    push_raw = 2'd0;
    res0     = '{kind: wsdf_pkg::KIND_TEXT, data: 8'd0, last: 1'b0};
    res1     = '{kind: wsdf_pkg::KIND_TEXT, data: 8'd0, last: 1'b0};

    unique case (phase_q)
      PH_HDR1: begin
        mask_d = in_byte_q[7];
        key_d  = '0;
        rem_d  = '0;
        if (in_byte_q[6:0] == wsdf_pkg::LEN7_EXT16) begin
          cnt_d   = wsdf_pkg::HDR_CNT_EXT16;
          phase_d = PH_EXT;
        end else if (in_byte_q[6:0] == wsdf_pkg::LEN7_EXT64) begin
          cnt_d   = wsdf_pkg::HDR_CNT_EXT64;
          phase_d = PH_EXT;
        end else begin
          rem_d    = LEN_BITS'(in_byte_q[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        if (rem_q[LEN_BITS-1 -: 8] != 8'd0) begin
          rem_d = '1;
        end else begin
          rem_d = {rem_q[LEN_BITS-9:0], in_byte_q};
        end
        cnt_d    = cnt_q - 4'd1;
        len_done = (cnt_d == 4'd0);
      end
      PH_KEY: begin
        key_d    = {key_q[23:0], in_byte_q};
        cnt_d    = cnt_q - 4'd1;
        hdr_done = (cnt_d == 4'd0);
      end
      PH_PAY: begin
        rem_d    = rem_q - LEN_BITS'(1);
        mphase_d = mphase_q + 2'd1;
        fin      = (rem_d == '0);
        if (fin) begin
          phase_d = PH_HDR0;
        end
        if (op_q == wsdf_pkg::OP_TEXT) begin
          res0     = '{kind: wsdf_pkg::KIND_TEXT, data: pay_byte, last: fin};
          push_raw = 2'd1;
        end else if (op_q == wsdf_pkg::OP_PING) begin
          res0     = '{kind: wsdf_pkg::KIND_PONG, data: pay_byte, last: fin};
          push_raw = 2'd1;
        end else if (op_q == wsdf_pkg::OP_CLOSE && fin) begin
          res0     = '{kind: wsdf_pkg::KIND_CLOSE, data: 8'd0, last: 1'b0};
          push_raw = 2'd1;
        end
      end
      default: begin
        op_d    = in_byte_q[3:0];
        phase_d = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_d) begin
        cnt_d   = wsdf_pkg::HDR_CNT_KEY;
        phase_d = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    empty = (rem_d == '0);
    if (hdr_done) begin
      mphase_d = 2'd0;
      phase_d  = empty ? PH_HDR0 : PH_PAY;
      if (op_q == wsdf_pkg::OP_PING) begin
        res0     = '{kind: wsdf_pkg::KIND_PONG, data: wsdf_pkg::PONG_HDR, last: 1'b0};
        res1     = '{kind: wsdf_pkg::KIND_PONG, data: rem_d[7:0], last: empty};
        push_raw = 2'd2;
      end else if (empty && op_q == wsdf_pkg::OP_TEXT) begin
        res0     = '{kind: wsdf_pkg::KIND_EMPTY, data: 8'd0, last: 1'b1};
        push_raw = 2'd1;
      end else if (empty && op_q == wsdf_pkg::OP_CLOSE) begin
        res0     = '{kind: wsdf_pkg::KIND_CLOSE, data: 8'd0, last: 1'b0};
        push_raw = 2'd1;
      end
    end
  end

  assign push_cnt = fire ? push_raw : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      cnt_q    <= '0;
      op_q     <= '0;
      mask_q   <= 1'b0;
      key_q    <= '0;
      rem_q    <= '0;
      mphase_q <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      op_q     <= op_d;
      mask_q   <= mask_d;
      key_q    <= key_d;
      rem_q    <= rem_d;
      mphase_q <= mphase_d;
    end
  end

  assign pop = out_valid_o && !out_stall_i;

  wsdf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (pop),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign kind_o = head.kind;
  assign data_o = head.data;
  assign last_o = head.last;

endmodule

`default_nettype wire

### rtl/wsdf_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on wsdf_pkg for the result type.
`default_nettype none

module wsdf_fifo #(
  parameter int unsigned DEPTH = wsdf_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_cnt_i,
  input  wire wsdf_pkg::result_t push0_i,
  input  wire wsdf_pkg::result_t push1_i,
  input  wire logic              pop_i,
  output logic                   room2_o,
  output logic                   valid_o,
  output wsdf_pkg::result_t      head_o
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wsdf_pkg::result_t mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_q);

  always_comb begin
    case (push_cnt_i)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_ptr1;
      default: wr_ptr_d = ptr_inc(wr_ptr1);
    endcase
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push_cnt_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign room2_o = (count_q <= CW'(DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/wsdf_chk.sv
// Port-level checker for the WebSocket frame deframer, bound to the top level.
// Depends on wsdf_pkg for the result kind codes.
`default_nettype none

module wsdf_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] data_o,
  input wire logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(data_o) && $stable(last_o))
    else $error("stalled output transaction changed");

  a_close_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wsdf_pkg::KIND_CLOSE |-> data_o == 8'd0 && !last_o)
    else $error("close event carries data or last");

  a_empty_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wsdf_pkg::KIND_EMPTY |-> data_o == 8'd0 && last_o)
    else $error("empty text event malformed");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind websocket_frame_deframer wsdf_chk u_wsdf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .data_o      (data_o),
  .last_o      (last_o)
);

`default_nettype wire

### tb/websocket_frame_deframer_tb.sv
// Self-checking testbench for websocket_frame_deframer: directed frames, then random frames
// with noise, under several idle and stall mixes. Depends on wsdf_pkg and the deframer RTL.
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsdf_pkg::*;

  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_BITS_DEF);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } deframe_phase_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [1:0] n_typed;
    result_t    t0;
    result_t    t1;
  } stim_row_t;

  localparam result_t NO_RESULT = '{kind: KIND_TEXT, data: 8'h00, last: 1'b0};

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{8'h89, 1'b1, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b1, 2'd2, '{KIND_PONG, PONG_HDR, 1'b0}, '{KIND_PONG, 8'h00, 1'b1}},
    '{8'h01, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h80, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b1, 2'd1, '{KIND_EMPTY, 8'h00, 1'b1}, NO_RESULT},
    '{8'h88, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b1, 2'd1, '{KIND_CLOSE, 8'h00, 1'b0}, NO_RESULT},
    '{8'hE9, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h83, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h12, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h34, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h56, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h78, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hFF, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hAA, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h82, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h7E, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h00, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'h01, 1'b0, 2'd0, NO_RESULT, NO_RESULT},
    '{8'hA5, 1'b0, 2'd0, NO_RESULT, NO_RESULT}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] data_o;
  logic       last_o;

  websocket_frame_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  deframe_phase_e ph = PH_FIRST;
  logic [3:0]     hdr_left = '0;
  logic [3:0]     opcode = '0;
  logic           masked = 1'b0;
  logic [31:0]    key = '0;
  logic [63:0]    remaining = '0;
  logic [1:0]     key_idx = '0;

  result_t     step_out [2];
  int          step_n;
  result_t     awaited_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned accepted_bytes = 0;
  int unsigned mismatch_count = 0;

  task automatic emit(input kind_e k, input logic [7:0] d, input logic l);
    step_out[step_n] = '{kind: k, data: d, last: l};
    step_n++;
  endtask

  task automatic queue_result(input result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic close_header();
    logic empty;
    empty = (remaining == 0);
    key_idx = '0;
    if (opcode == OP_PING) begin
      emit(KIND_PONG, PONG_HDR, 1'b0);
      emit(KIND_PONG, remaining[7:0], empty);
    end else if (empty && opcode == OP_TEXT) begin
      emit(KIND_EMPTY, 8'h00, 1'b1);
    end else if (empty && opcode == OP_CLOSE) begin
      emit(KIND_CLOSE, 8'h00, 1'b0);
    end
    ph = empty ? PH_FIRST : PH_PAYLOAD;
  endtask

  task automatic close_length();
    if (masked) begin
      hdr_left = HDR_CNT_KEY;
      ph = PH_KEY;
    end else begin
      close_header();
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] plain;
    logic       fin;
    step_n = 0;
    case (ph)
      PH_SECOND: begin
        masked = b[7];
        key = '0;
        remaining = '0;
        if (b[6:0] == LEN7_EXT16) begin
          hdr_left = HDR_CNT_EXT16;
          ph = PH_EXTLEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          hdr_left = HDR_CNT_EXT64;
          ph = PH_EXTLEN;
        end else begin
          remaining = 64'(b[6:0]);
          close_length();
        end
      end
      PH_EXTLEN: begin
        if (remaining > (LEN_MASK >> 8)) remaining = LEN_MASK;
        else remaining = ((remaining << 8) | 64'(b)) & LEN_MASK;
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) close_length();
      end
      PH_KEY: begin
        key = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) close_header();
      end
      PH_PAYLOAD: begin
        plain = b ^ 8'(key >> (24 - 8 * int'(key_idx)));
        remaining = (remaining - 64'd1) & LEN_MASK;
        key_idx = key_idx + 2'd1;
        fin = (remaining == 0);
        if (fin) ph = PH_FIRST;
        if (opcode == OP_TEXT) emit(KIND_TEXT, plain, fin);
        else if (opcode == OP_PING) emit(KIND_PONG, plain, fin);
        else if (opcode == OP_CLOSE && fin) emit(KIND_CLOSE, 8'h00, 1'b0);
      end
      default: begin
        opcode = b[3:0];
        ph = PH_SECOND;
      end
    endcase
  endtask

  task automatic send_byte(input stim_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= row.rx;
    do @(posedge clk_i); while (in_stall_o);
    parse_rx_byte(row.rx);
    if (row.typed) begin
      if (row.n_typed > 0) queue_result(row.t0);
      if (row.n_typed > 1) queue_result(row.t1);
    end else begin
      for (int i = 0; i < step_n; i++) queue_result(step_out[i]);
    end
    accepted_bytes++;
  endtask

  task automatic send_raw(input logic [7:0] b);
    send_byte('{b, 1'b0, 2'd0, NO_RESULT, NO_RESULT});
  endtask

  // keep extended lengths short so the parser never gets stuck in a payload
  function automatic logic [7:0] filler_byte();
    if (ph == PH_EXTLEN && hdr_left > 4'd2) return 8'h00;
    if (ph == PH_EXTLEN && hdr_left == 4'd2) return 8'($urandom_range(1));
    return 8'($urandom());
  endfunction

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(6, 1);
    repeat (n) send_raw(filler_byte());
    while (ph != PH_FIRST) send_raw(filler_byte());
  endtask

  task automatic send_frame();
    logic [3:0]  op;
    logic        msk;
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(9);
    op = (sel < 4) ? OP_TEXT : (sel < 6) ? OP_PING : (sel < 8) ? OP_CLOSE
                                                               : 4'($urandom_range(15));
    msk = 1'($urandom_range(1));
    sel = $urandom_range(19);
    if (sel < 12) len = $urandom_range(8);
    else if (sel < 16) len = $urandom_range(125);
    else if (sel < 18) len = $urandom_range(300);
    else len = $urandom_range(40);
    send_raw({4'($urandom_range(15)), op});
    if (sel == 16 || sel == 17) begin
      send_raw({msk, LEN7_EXT16});
      send_raw(8'(len >> 8));
      send_raw(8'(len));
    end else if (sel >= 18) begin
      send_raw({msk, LEN7_EXT64});
      repeat (6) send_raw(8'h00);
      send_raw(8'(len >> 8));
      send_raw(8'(len));
    end else begin
      send_raw({msk, 7'(len)});
    end
    if (msk) repeat (4) send_raw(8'($urandom()));
    repeat (len) send_raw(8'($urandom()));
  endtask

  task automatic report_field(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_field("unexpected transaction kind", -1, kind_o);
      end else begin
        want = awaited_results.pop_front();
        if (kind_o !== want.kind) report_field("kind", want.kind, kind_o);
        if (data_o !== want.data) report_field("data", want.data, data_o);
        if (last_o !== want.last) report_field("last", want.last, last_o);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[websocket_frame_deframer] ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) send_byte(DIRECTED_ROWS[i]);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (p == 0) begin
        // hold the output while a long text frame keeps arriving
        hold_cycles = 150;
        send_raw({4'h8, OP_TEXT});
        send_raw(8'd60);
        repeat (60) send_raw(8'($urandom()));
      end
      while (accepted_bytes < 24 + (p + 1) * 265) begin
        send_frame();
        if ($urandom_range(99) < 15) send_noise();
      end
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (awaited_results.size() != 0);
    end

    // masked text frame with an all-ones 64-bit length, high bit of the first byte set
    send_raw({4'h8, OP_TEXT});
    send_raw({1'b1, LEN7_EXT64});
    repeat (8) send_raw(8'hFF);
    repeat (4) send_raw(8'($urandom()));
    repeat (30) send_raw(8'($urandom()));
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (awaited_results.size() != 0);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[websocket_frame_deframer] OK");
    end else begin
      $display("[websocket_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/wsdf_pkg.sv
rtl/wsdf_fifo.sv
rtl/websocket_frame_deframer.sv
rtl/wsdf_chk.sv
tb/websocket_frame_deframer_tb.sv
